// ===== hdl/lars_pkg.sv =====
package lars_pkg;

    // width of one grid line on the ports
    localparam int unsigned LINE_W = 64;

    // bits of a live-neighbor count (0 to 8)
    localparam int unsigned CNT_W = 4;

    // one column as seen by its neighbors
    typedef struct packed {
        logic upper;
        logic middle;
        logic down;
    } lars_col_t;

    // control shared by every cell of the row
    typedef struct packed {
        logic shift_en;
        logic clear;
    } lars_cell_ctrl_t;

endpackage

// ===== hdl/lars_cell.sv =====
module lars_cell
    import lars_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  lars_cell_ctrl_t ctrl,
    input  logic            down_bit,
    input  lars_col_t       left_col,
    input  lars_col_t       right_col,
    output lars_col_t       own_col,
    output logic            next_bit
);

    logic upper_reg;
    logic middle_reg;
    logic [CNT_W-1:0] count;

    // column state: cleared on reset or clear; on a shift, middle moves up and the new line bit becomes the middle
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end else if (ctrl.shift_en) begin
            upper_reg  <= middle_reg;
            middle_reg <= down_bit;
        end
    end

    assign own_col.upper  = upper_reg;
    assign own_col.middle = middle_reg;
    assign own_col.down   = down_bit;

    // live neighbors around the middle cell
    assign count = CNT_W'(left_col.upper)  + CNT_W'(left_col.middle)  + CNT_W'(left_col.down)
                 + CNT_W'(right_col.upper) + CNT_W'(right_col.middle) + CNT_W'(right_col.down)
                 + CNT_W'(upper_reg)       + CNT_W'(down_bit);

    // born on three, survives on two or three
    assign next_bit = (count == CNT_W'(3)) || ((count == CNT_W'(2)) && middle_reg);

endmodule

// ===== hdl/life_automaton_row_step.sv =====
// a result beat is registered and valid in the cycle after the line beat that completes it
// throughput: one line per cycle while m_ready allows; a final line's second result blocks input
// the row of COLS cells holds the two previous lines, one column per cell
// reset (aresetn low, synchronous) clears the held lines, the frame state and m_valid
module life_automaton_row_step
    import lars_pkg::*;
#(
    parameter int unsigned COLS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [LINE_W-1:0] s_line_cells,
    input  logic              s_final_line,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [LINE_W-1:0] m_next_line,
    output logic              m_frame_done
);

    logic              held_reg;
    logic              held_next;
    logic              flush_reg;
    logic              flush_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [LINE_W-1:0] next_line_reg;
    logic              frame_done_reg;

    logic              out_free;
    logic              accept;
    logic              flush_fire;
    logic              emit;
    logic [COLS-1:0]   down_vec;
    logic [COLS-1:0]   next_vec;
    lars_cell_ctrl_t   cell_ctrl;
    lars_col_t         col_vec [COLS];

    // handshake and control
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = out_free && !flush_reg;
    assign accept     = s_valid && s_ready;
    assign flush_fire = flush_reg && out_free;
    assign emit       = (accept && held_reg) || flush_fire;

    // the line below is dead while the frame's last line is flushed
    assign down_vec = flush_reg ? '0 : s_line_cells[COLS-1:0];

    assign cell_ctrl.shift_en = accept;
    assign cell_ctrl.clear    = flush_fire;

    // row of cells, each talking to its neighbors; the edge columns see dead cells beyond the row
    for (genvar c = 0; c < COLS; c++) begin : g_cell
        lars_col_t left_col;
        lars_col_t right_col;

        if (c == 0) begin : g_left_edge
            assign left_col = '0;
        end else begin : g_left_inner
            assign left_col = col_vec[c-1];
        end

        if (c == COLS - 1) begin : g_right_edge
            assign right_col = '0;
        end else begin : g_right_inner
            assign right_col = col_vec[c+1];
        end

        lars_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .down_bit  (down_vec[c]),
            .left_col  (left_col),
            .right_col (right_col),
            .own_col   (col_vec[c]),
            .next_bit  (next_vec[c])
        );
    end

    // next frame state
    always_comb begin
        held_next    = held_reg;
        flush_next   = flush_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            held_next = 1'b1;
            if (s_final_line) begin
                flush_next = 1'b1;
            end
        end
        if (flush_fire) begin
            held_next  = 1'b0;
            flush_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= 1'b0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            held_reg    <= held_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (emit) begin
            next_line_reg  <= LINE_W'(next_vec);
            frame_done_reg <= flush_fire;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_next_line  = next_line_reg;
    assign m_frame_done = frame_done_reg;

endmodule
